### design/frm_pkg.sv
// shared types and constants of the frame receiver
package frm_pkg;

    localparam int FRAME_LEN  = 10;
    localparam int POS_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int SUM_W      = 11;
    localparam int SUM_LO_POS = 7;
    localparam int SUM_HI_POS = 8;
    localparam int DATA_CNT   = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL = 1'b1;

    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'd170;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'd85;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_STORED = 2'd1,
        ST_ACCEPT = 2'd2,
        ST_DROP   = 2'd3
    } frame_status_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } byte_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] head;
        logic [BYTE_W-1:0] tail;
    } frame_cfg_t;

endpackage

### design/frm_byte_if.sv
// input channel carrying one received byte per word
interface frm_byte_if;
    import frm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### design/frm_result_if.sv
// output channel carrying one frame result per word
interface frm_result_if;
    import frm_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        frame_status;
    logic              checksum_ok;
    logic [BYTE_W-1:0] command_byte;
    logic [BYTE_W-1:0] data_one;
    logic [BYTE_W-1:0] data_two;
    logic [BYTE_W-1:0] data_three;
    logic [BYTE_W-1:0] data_four;
    logic [BYTE_W-1:0] data_five;

    modport source (
        output valid, output frame_status, output checksum_ok, output command_byte,
        output data_one, output data_two, output data_three, output data_four,
        output data_five, input ready
    );
    modport sink (
        input valid, input frame_status, input checksum_ok, input command_byte,
        input data_one, input data_two, input data_three, input data_four,
        input data_five, output ready
    );
endinterface

### design/frm_cfg_regs.sv
// head and tail byte configuration registers
module frm_cfg_regs
    import frm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output frame_cfg_t           cfg
);

    logic [BYTE_W-1:0] head_reg;
    logic [BYTE_W-1:0] tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= HEAD_RESET;
            tail_reg <= TAIL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAD: head_reg <= cfg_data;
                CFG_TAIL: tail_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign cfg.head = head_reg;
    assign cfg.tail = tail_reg;

endmodule

### design/frm_in_stage.sv
// input register in front of the frame assembler
module frm_in_stage
    import frm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    frm_byte_if.sink      rx,
    input  logic          down_ready,
    output byte_word_t    word
);

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;

    assign rx.ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            data_reg <= rx.rx_byte;
        end
    end

    assign word.valid = valid_reg;
    assign word.data  = data_reg;

endmodule

### design/frm_assembler.sv
// frame position, byte store, tail and checksum checks and result register
module frm_assembler
    import frm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  byte_word_t    word,
    input  frame_cfg_t    cfg,
    output logic          take,
    frm_result_if.source  res
);

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [BYTE_W-1:0] bytes_reg [1:SUM_HI_POS];

    logic              out_valid_reg;
    frame_status_t     status_reg;
    logic              sum_ok_reg;
    logic [BYTE_W-1:0] cmd_reg;
    logic [BYTE_W-1:0] data_reg [0:DATA_CNT-1];

    frame_status_t     status_next;
    logic              sum_ok_next;
    logic [SUM_W-1:0]  sum;
    logic              accept;

    assign take = word.valid && (!out_valid_reg || res.ready);

    // sum of command and data bytes one to four
    always_comb
    begin
        sum = '0;
        for (int k = 1; k <= DATA_CNT; k++)
        begin
            sum = sum + SUM_W'(bytes_reg[k]);
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        status_next = ST_IDLE;
        accept      = 1'b0;
        if (pos_reg == '0)
        begin
            if (word.data == cfg.head)
            begin
                pos_next    = POS_W'(1);
                status_next = ST_STORED;
            end
        end
        else if (pos_reg == POS_W'(FRAME_LEN - 1))
        begin
            pos_next = '0;
            if (word.data == cfg.tail)
            begin
                status_next = ST_ACCEPT;
                accept      = 1'b1;
            end
            else
            begin
                status_next = ST_DROP;
            end
        end
        else
        begin
            pos_next    = pos_reg + POS_W'(1);
            status_next = ST_STORED;
        end
        sum_ok_next = accept
                      && ({bytes_reg[SUM_HI_POS], bytes_reg[SUM_LO_POS]}
                          == (2*BYTE_W)'(sum));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pos_reg <= pos_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int k = 1; k <= SUM_HI_POS; k++)
            begin
                if (pos_reg == POS_W'(k))
                begin
                    bytes_reg[k] <= word.data;
                end
            end
            status_reg <= status_next;
            sum_ok_reg <= sum_ok_next;
            cmd_reg    <= accept ? bytes_reg[1] : '0;
            for (int k = 0; k < DATA_CNT; k++)
            begin
                data_reg[k] <= accept ? bytes_reg[k + 2] : '0;
            end
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.frame_status = status_reg;
    assign res.checksum_ok  = sum_ok_reg;
    assign res.command_byte = cmd_reg;
    assign res.data_one     = data_reg[0];
    assign res.data_two     = data_reg[1];
    assign res.data_three   = data_reg[2];
    assign res.data_four    = data_reg[3];
    assign res.data_five    = data_reg[4];

endmodule

### design/frame_receiver_with_checksum.sv
// frame receiver with additive checksum, top level
//
//   channel  direction  word
//   rx       in         rx_byte
//   res      out        frame_status, checksum_ok, command_byte, data_one..data_five
//   cfg      in         cfg_we, cfg_index, cfg_data (0 head byte, 1 tail byte)
//
// one word in and one result out per cycle while res is not stalled; input register,
// then position compare, tail compare and five-byte sum into the result register
// rst_n clears the input and result valid flags and returns the position to idle
// a stalled result holds the result register; the input register still takes one word
module frame_receiver_with_checksum
    import frm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    frm_byte_if.sink             rx,
    frm_result_if.source         res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    frame_cfg_t cfg;
    byte_word_t word;
    logic       take;

    frm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    frm_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .down_ready (take),
        .word       (word)
    );

    frm_assembler u_asm (
        .clk   (clk),
        .rst_n (rst_n),
        .word  (word),
        .cfg   (cfg),
        .take  (take),
        .res   (res)
    );

    a_zero_unless_accept: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.frame_status != ST_ACCEPT
        |-> !res.checksum_ok && res.command_byte == '0 && res.data_five == '0)
        else $error("result fields not cleared outside an accepted frame");

    a_held_word_waits: assert property (@(posedge clk) disable iff (!rst_n)
        word.valid && !take |=> word.valid && $stable(word.data))
        else $error("input register lost a word");

    a_result_from_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(word.valid))
        else $error("result without an input word");

    a_take_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !res.valid || res.ready)
        else $error("word processed while result stalled");

endmodule
